### hdl/pqts_pkg.sv
// ----------------------------------------------------------------------------
// pqts_pkg
// shared types, codes and sizes of the priority quantum task scheduler
// ----------------------------------------------------------------------------
package pqts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int TIDW      = 3;                       // task number width
  localparam int CNTW      = $clog2(MAX_TASKS + 1);   // list fill count width
  localparam int QW        = 9;                       // quantum counter width

  typedef logic [TIDW-1:0] task_t;
  typedef logic [CNTW-1:0] cnt_t;
  typedef logic [7:0]      prio_t;
  typedef logic [QW-1:0]   quant_t;
  typedef logic [1:0]      place_t;

  typedef logic [MAX_TASKS-1:0][TIDW-1:0] order_vec_t;
  typedef logic [MAX_TASKS-1:0][7:0]      prio_vec_t;

  localparam place_t PLACE_ABSENT  = 2'd0;
  localparam place_t PLACE_READY   = 2'd1;
  localparam place_t PLACE_WAITING = 2'd2;
  localparam place_t PLACE_BLOCKED = 2'd3;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_SVC     = 3'd1;
  localparam logic [2:0] KIND_TIMER   = 3'd2;
  localparam logic [2:0] KIND_IRQ     = 3'd3;
  localparam logic [2:0] KIND_WAITING = 3'd4;
  localparam logic [2:0] KIND_BLOCKED = 3'd5;
  localparam logic [2:0] KIND_CREATE  = 3'd6;

  localparam logic [1:0] REG_IDLE_QUANTUM  = 2'd0;
  localparam logic [1:0] REG_IDLE_PRIORITY = 2'd1;

  localparam logic SCAN_FIND = 1'b0;   // look for a task in the list
  localparam logic SCAN_POS  = 1'b1;   // look for the sorted insert slot

  typedef struct packed {
    logic  mode;
    task_t key;
    cnt_t  idx;
    cnt_t  count;
  } scan_req_t;

  typedef struct packed {
    logic hit;
    logic past_end;
  } scan_rsp_t;

endpackage

### hdl/pqts_ifs.sv
// ----------------------------------------------------------------------------
// pqts channel interfaces
// valid/ready channels of the scheduler: input words, result words, config
// ----------------------------------------------------------------------------
interface pqts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] task_id;
  logic [7:0] task_priority;
  logic [7:0] cpu_time;
  modport source (output valid, kind, task_id, task_priority, cpu_time, input ready);
  modport sink   (input valid, kind, task_id, task_priority, cpu_time, output ready);
endinterface

interface pqts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  running_task;
  logic [31:0] tick_count;
  logic        irq_pending;
  logic        status;
  modport source (output valid, running_task, tick_count, irq_pending, status, input ready);
  modport sink   (input valid, running_task, tick_count, irq_pending, status, output ready);
endinterface

interface pqts_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pqts_scan_unit.sv
// ----------------------------------------------------------------------------
// pqts_scan_unit
// shared compare unit that the sequencer steps along the ready list
// ----------------------------------------------------------------------------
module pqts_scan_unit (
  input  pqts_pkg::scan_req_t  req,
  input  pqts_pkg::order_vec_t order,
  input  pqts_pkg::prio_vec_t  prio,
  output pqts_pkg::scan_rsp_t  rsp
);

  pqts_pkg::task_t entry;

  assign entry = order[req.idx[pqts_pkg::TIDW-1:0]];

  always_comb begin
    rsp.past_end = (req.idx >= req.count);
    if (req.mode == pqts_pkg::SCAN_POS) begin
      rsp.hit = (prio[req.key] >= prio[entry]);
    end else begin
      rsp.hit = (entry == req.key);
    end
  end

endmodule

### hdl/priority_quantum_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_quantum_task_scheduler_unit
// priority round-robin task scheduler with per-task quantum and irq wakes
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          kind, task_id, task_priority, cpu_time
//  out_ch    out  valid/ready          running_task, tick_count, irq_pending, status
//  cfg_ch    in   valid/ready          index, data (0 idle_quantum, 1 idle priority)
//
//  a rejected word goes straight to the finish step; the work of any other word
//  is set by the list walk, one ready-list slot per cycle through the shared
//  scan unit. an idle priority write walks the list twice.
//  rst_n is synchronous and restores idle task 0 alone in the list.
//  in_ch is not ready while a word is in work; a held result stalls only the
//  finish step, and the next word may be taken while the result waits
// ----------------------------------------------------------------------------
module priority_quantum_task_scheduler_unit (
  input  logic       clk,
  input  logic       rst_n,
  pqts_in_if.sink    in_ch,
  pqts_out_if.source out_ch,
  pqts_cfg_if.sink   cfg_ch
);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_FIND   = 3'd2;
  localparam logic [2:0] ST_POS    = 3'd3;
  localparam logic [2:0] ST_WAKE   = 3'd4;
  localparam logic [2:0] ST_PEND   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  localparam int MT = pqts_pkg::MAX_TASKS;

  logic [2:0] state_r, state_nxt;

  // scheduler state
  pqts_pkg::order_vec_t ro_r, ro_nxt;
  pqts_pkg::cnt_t       cnt_r, cnt_nxt;
  pqts_pkg::prio_vec_t  prio_r, prio_nxt;
  logic [MT-1:0][7:0]   reload_r, reload_nxt;
  logic [MT-1:0][pqts_pkg::QW-1:0] qleft_r, qleft_nxt;
  logic [MT-1:0][1:0]   place_r, place_nxt;
  pqts_pkg::task_t      cur_r, cur_nxt;
  pqts_pkg::task_t      pend_task_r, pend_task_nxt;
  pqts_pkg::prio_t      pend_level_r, pend_level_nxt;
  logic [31:0]          tick_r, tick_nxt;

  // latched word and sequencer working registers
  logic [2:0]       kind_r, kind_nxt;
  pqts_pkg::task_t  tid_r, tid_nxt;
  pqts_pkg::prio_t  tprio_r, tprio_nxt;
  logic [7:0]       cpu_r, cpu_nxt;
  logic             cfg_op_r, cfg_op_nxt;
  logic [7:0]       cfg_val_r, cfg_val_nxt;
  pqts_pkg::task_t  key_r, key_nxt;
  pqts_pkg::cnt_t   idx_r, idx_nxt;
  logic             status_r, status_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  pqts_pkg::task_t  out_task_r, out_task_nxt;
  logic [31:0]      out_tick_r, out_tick_nxt;
  logic             out_irq_r, out_irq_nxt;
  logic             out_status_r, out_status_nxt;

  pqts_pkg::scan_req_t scan_req;
  pqts_pkg::scan_rsp_t scan_rsp;

  pqts_scan_unit u_scan (
    .req   (scan_req),
    .order (ro_r),
    .prio  (prio_r),
    .rsp   (scan_rsp)
  );

  assign scan_req.mode  = (state_r == ST_POS) ? pqts_pkg::SCAN_POS : pqts_pkg::SCAN_FIND;
  assign scan_req.key   = key_r;
  assign scan_req.idx   = idx_r;
  assign scan_req.count = cnt_r;

  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.running_task = out_task_r;
  assign out_ch.tick_count   = out_tick_r;
  assign out_ch.irq_pending  = out_irq_r;
  assign out_ch.status       = out_status_r;

  // helpers
  logic             tid_ok;
  pqts_pkg::quant_t q_dec;
  pqts_pkg::cnt_t   slot;       // slot found by the walk
  pqts_pkg::cnt_t   slot_inc;
  pqts_pkg::task_t  succ;       // list entry after the found slot, or head
  logic             succ_in;
  logic             beats;

  assign tid_ok   = (tid_r != '0) &&
                    ({1'b0, tid_r} < (pqts_pkg::TIDW + 1)'(MT));
  assign q_dec    = (qleft_r[cur_r] != '0) ? qleft_r[cur_r] - 1'b1 : '0;
  assign slot     = (!scan_rsp.past_end && scan_rsp.hit) ? idx_r : '0;
  assign slot_inc = slot + 1'b1;
  assign succ_in  = (slot_inc < cnt_r) && (slot_inc < pqts_pkg::CNTW'(MT));
  assign succ     = succ_in ? ro_r[slot_inc[pqts_pkg::TIDW-1:0]] : ro_r[0];
  assign beats    = (prio_r[tid_r] >= prio_r[cur_r]) && (prio_r[tid_r] >= pend_level_r);

  always_comb begin
    state_nxt      = state_r;
    ro_nxt         = ro_r;
    cnt_nxt        = cnt_r;
    prio_nxt       = prio_r;
    reload_nxt     = reload_r;
    qleft_nxt      = qleft_r;
    place_nxt      = place_r;
    cur_nxt        = cur_r;
    pend_task_nxt  = pend_task_r;
    pend_level_nxt = pend_level_r;
    tick_nxt       = tick_r;
    kind_nxt       = kind_r;
    tid_nxt        = tid_r;
    tprio_nxt      = tprio_r;
    cpu_nxt        = cpu_r;
    cfg_op_nxt     = cfg_op_r;
    cfg_val_nxt    = cfg_val_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_task_nxt   = out_task_r;
    out_tick_nxt   = out_tick_r;
    out_irq_nxt    = out_irq_r;
    out_status_nxt = out_status_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_ch.valid) begin
          if (cfg_ch.index == pqts_pkg::REG_IDLE_QUANTUM) begin
            reload_nxt[0] = cfg_ch.data;
            qleft_nxt[0]  = {1'b0, cfg_ch.data};
          end else if (cfg_ch.index == pqts_pkg::REG_IDLE_PRIORITY) begin
            // pull task 0 out of the list and sort it back in
            cfg_op_nxt  = 1'b1;
            cfg_val_nxt = cfg_ch.data;
            key_nxt     = '0;
            idx_nxt     = '0;
            state_nxt   = ST_FIND;
          end
        end else if (in_ch.valid) begin
          kind_nxt   = in_ch.kind;
          tid_nxt    = in_ch.task_id;
          tprio_nxt  = in_ch.task_priority;
          cpu_nxt    = in_ch.cpu_time;
          cfg_op_nxt = 1'b0;
          status_nxt = 1'b0;
          state_nxt  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        idx_nxt = '0;
        case (kind_r)
          pqts_pkg::KIND_TICK: begin
            tick_nxt = tick_r + 32'd1;
            if (q_dec == '0) begin
              // quantum expired: reload and rotate past the running task
              qleft_nxt[cur_r] = {1'b0, reload_r[cur_r]};
              key_nxt          = cur_r;
              state_nxt        = ST_FIND;
            end else begin
              qleft_nxt[cur_r] = q_dec;
              state_nxt        = ST_PEND;
            end
          end
          pqts_pkg::KIND_SVC, pqts_pkg::KIND_TIMER, pqts_pkg::KIND_IRQ: begin
            if (!tid_ok || place_r[tid_r] == pqts_pkg::PLACE_ABSENT ||
                (place_r[tid_r] == pqts_pkg::PLACE_READY && kind_r != pqts_pkg::KIND_TIMER)) begin
              status_nxt = 1'b1;
              state_nxt  = ST_FINISH;
            end else if (place_r[tid_r] != pqts_pkg::PLACE_READY) begin
              place_nxt[tid_r] = pqts_pkg::PLACE_READY;
              key_nxt          = tid_r;
              state_nxt        = ST_POS;
            end else begin
              state_nxt = ST_WAKE;
            end
          end
          pqts_pkg::KIND_WAITING, pqts_pkg::KIND_BLOCKED: begin
            if (cur_r == '0 || place_r[cur_r] != pqts_pkg::PLACE_READY) begin
              status_nxt = 1'b1;
              state_nxt  = ST_FINISH;
            end else begin
              key_nxt   = cur_r;
              state_nxt = ST_FIND;
            end
          end
          pqts_pkg::KIND_CREATE: begin
            if (!tid_ok || place_r[tid_r] != pqts_pkg::PLACE_ABSENT || cpu_r == '0) begin
              status_nxt = 1'b1;
              state_nxt  = ST_FINISH;
            end else begin
              prio_nxt[tid_r]   = tprio_r;
              reload_nxt[tid_r] = cpu_r;
              qleft_nxt[tid_r]  = {1'b0, cpu_r};
              place_nxt[tid_r]  = pqts_pkg::PLACE_READY;
              key_nxt           = tid_r;
              state_nxt         = ST_POS;
            end
          end
          default: begin
            status_nxt = 1'b1;
            state_nxt  = ST_FINISH;
          end
        endcase
      end

      // walk the list for key_r, one slot a cycle
      ST_FIND: begin
        if (!scan_rsp.past_end && !scan_rsp.hit) begin
          idx_nxt = idx_r + 1'b1;
        end else if (cfg_op_r) begin
          if (cnt_r != '0 && ro_r[slot[pqts_pkg::TIDW-1:0]] == key_r) begin
            for (int j = 0; j < MT - 1; j++) begin
              if (pqts_pkg::CNTW'(j) >= slot && pqts_pkg::CNTW'(j + 1) < cnt_r) begin
                ro_nxt[j] = ro_r[j + 1];
              end
            end
            cnt_nxt = cnt_r - 1'b1;
          end
          prio_nxt[0] = cfg_val_r;
          idx_nxt     = '0;
          state_nxt   = ST_POS;
        end else if (kind_r == pqts_pkg::KIND_TICK) begin
          // the rotation skips the idle task and wraps to the head
          cur_nxt   = (succ_in && succ != '0) ? succ : ro_r[0];
          state_nxt = ST_PEND;
        end else begin
          // suspend: drop the running task from the list
          for (int j = 0; j < MT - 1; j++) begin
            if (pqts_pkg::CNTW'(j) >= slot && pqts_pkg::CNTW'(j + 1) < cnt_r) begin
              ro_nxt[j] = ro_r[j + 1];
            end
          end
          cnt_nxt        = cnt_r - 1'b1;
          place_nxt[cur_r] = (kind_r == pqts_pkg::KIND_WAITING) ?
                             pqts_pkg::PLACE_WAITING : pqts_pkg::PLACE_BLOCKED;
          cur_nxt        = succ;
          state_nxt      = ST_FINISH;
        end
      end

      // walk for the first entry of lower or equal priority, then insert
      ST_POS: begin
        if (!scan_rsp.past_end && !scan_rsp.hit) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          if (cnt_r < pqts_pkg::CNTW'(MT)) begin
            for (int j = 1; j < MT; j++) begin
              if (pqts_pkg::CNTW'(j) > idx_r && pqts_pkg::CNTW'(j) <= cnt_r) begin
                ro_nxt[j] = ro_r[j - 1];
              end
            end
            ro_nxt[idx_r[pqts_pkg::TIDW-1:0]] = key_r;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (cfg_op_r) begin
            state_nxt = ST_IDLE;
          end else if (kind_r == pqts_pkg::KIND_CREATE) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_WAKE;
          end
        end
      end

      ST_WAKE: begin
        qleft_nxt[tid_r] = {1'b0, reload_r[tid_r]};
        if (beats) begin
          if (kind_r == pqts_pkg::KIND_IRQ) begin
            pend_task_nxt  = tid_r;
            pend_level_nxt = prio_r[tid_r];
          end else begin
            pend_level_nxt = '0;
            cur_nxt        = tid_r;
            if (kind_r == pqts_pkg::KIND_TIMER) begin
              qleft_nxt[tid_r] = {1'b0, reload_r[tid_r]} + 1'b1;
            end
          end
        end
        state_nxt = ST_FINISH;
      end

      // a pending irq request takes over once the tick is counted
      ST_PEND: begin
        if (pend_level_r != '0) begin
          if (place_r[pend_task_r] == pqts_pkg::PLACE_READY) begin
            cur_nxt = pend_task_r;
          end
          pend_level_nxt = '0;
        end
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_task_nxt   = cur_r;
          out_tick_nxt   = tick_r;
          out_irq_nxt    = (pend_level_r != '0);
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ro_r         <= '0;
      cnt_r        <= pqts_pkg::CNTW'(1);
      prio_r       <= '0;
      reload_r     <= {{(MT-1){8'd0}}, 8'd1};
      qleft_r      <= {{(MT-1){pqts_pkg::QW'(0)}}, pqts_pkg::QW'(1)};
      place_r      <= {{(MT-1){pqts_pkg::PLACE_ABSENT}}, pqts_pkg::PLACE_READY};
      cur_r        <= '0;
      pend_task_r  <= '0;
      pend_level_r <= '0;
      tick_r       <= '0;
      cfg_op_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ro_r         <= ro_nxt;
      cnt_r        <= cnt_nxt;
      prio_r       <= prio_nxt;
      reload_r     <= reload_nxt;
      qleft_r      <= qleft_nxt;
      place_r      <= place_nxt;
      cur_r        <= cur_nxt;
      pend_task_r  <= pend_task_nxt;
      pend_level_r <= pend_level_nxt;
      tick_r       <= tick_nxt;
      cfg_op_r     <= cfg_op_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tid_r        <= tid_nxt;
    tprio_r      <= tprio_nxt;
    cpu_r        <= cpu_nxt;
    cfg_val_r    <= cfg_val_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    status_r     <= status_nxt;
    out_task_r   <= out_task_nxt;
    out_tick_r   <= out_tick_nxt;
    out_irq_r    <= out_irq_nxt;
    out_status_r <= out_status_nxt;
  end

  // the list is never empty and never overfull
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= pqts_pkg::CNTW'(MT)))
    else $error("ready list count out of range");

  // idle task stays ready
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    place_r[0] == pqts_pkg::PLACE_READY)
    else $error("idle task left the ready state");

  // an accepted word starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_EXEC))
    else $error("accepted word did not start work");

  // a result only appears out of the finish step
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised outside finish");

endmodule
